FILE: rtl/cafl_pkg.sv
// Shared package for the 16-bit ALU with flags.
// It holds the opcode codes, the packet that travels down the pipeline and the
// divider state. No dependencies.
package cafl_pkg;

    localparam int unsigned DATA_W   = 16;
    localparam int unsigned CMD_W    = 5;
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned RES_W     = 21;

    typedef enum logic [CMD_W-1:0] {
        OP_MOV  = 5'd0,
        OP_ADD  = 5'd1,
        OP_SUB  = 5'd2,
        OP_UMUL = 5'd3,
        OP_SMUL = 5'd4,
        OP_UDIV = 5'd5,
        OP_SDIV = 5'd6,
        OP_UMOD = 5'd7,
        OP_SMOD = 5'd8,
        OP_AND  = 5'd9,
        OP_OR   = 5'd10,
        OP_XOR  = 5'd11,
        OP_NOT  = 5'd12,
        OP_NEG  = 5'd13,
        OP_INC  = 5'd14,
        OP_DEC  = 5'd15,
        OP_SHL  = 5'd16,
        OP_SHR  = 5'd17,
        OP_SAR  = 5'd18,
        OP_ROL  = 5'd19,
        OP_ROR  = 5'd20,
        OP_BTST = 5'd21,
        OP_ADC  = 5'd22,
        OP_SBC  = 5'd23,
        OP_MULC = 5'd24,
        OP_UCMP = 5'd30,
        OP_SCMP = 5'd31
    } opcode_t;

    // Everything an instruction carries besides the divider state.
    typedef struct packed {
        opcode_t             op;
        logic [DATA_W-1:0]   dval;
        logic [DATA_W-1:0]   sval;
        logic [DATA_W-1:0]   res;
        logic [2*DATA_W-1:0] prod;
        logic                cy;
        logic                zf;
        logic                wr;
        logic                ill;
        logic                dz;
        logic                ci;
        logic                neg_q;
        logic                neg_r;
    } pkt_t;

    // Restoring divider state: the dividend shifts out of n_q as quotient bits shift in.
    typedef struct packed {
        logic [DATA_W-1:0] n_q;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] den;
    } div_t;

endpackage

FILE: rtl/cafl_prep.sv
// First pipeline stage: unpacks the input transfer, computes the simple
// operations, the raw 16x16 product and the divider operands. Depends on cafl_pkg.
module cafl_prep (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cafl_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            valid_o,
    input  logic                            ready_i,
    output cafl_pkg::pkt_t                  pkt_o,
    output cafl_pkg::div_t                  div_o
);
    import cafl_pkg::*;

    logic              valid_reg;
    pkt_t              pkt_reg, pkt_next;
    div_t              div_reg, div_next;
    logic [DATA_W-1:0] d, s;
    logic              ci;
    logic [DATA_W:0]   sum17, dif17;
    logic [2*DATA_W-1:0] dd;
    logic [3:0]        rot;
    logic              big;

    assign d   = s_tdata[20:5];
    assign s   = s_tdata[36:21];
    assign ci  = s_tdata[37];
    assign rot = s[3:0];
    assign big = |s[DATA_W-1:4];
    assign dd  = {d, d};

    always_comb begin
        pkt_next       = '0;
        pkt_next.op    = opcode_t'(s_tdata[4:0]);
        pkt_next.dval  = d;
        pkt_next.sval  = s;
        pkt_next.res   = d;
        pkt_next.wr    = 1'b1;
        pkt_next.ci    = ci;
        pkt_next.prod  = {16'h0, d} * {16'h0, s};
        pkt_next.neg_q = d[15] ^ s[15];
        pkt_next.neg_r = d[15];
        sum17 = {1'b0, d} + {1'b0, s} + {16'h0, ci & (pkt_next.op == OP_ADC)};
        dif17 = {1'b0, d} - {1'b0, s} - {16'h0, ci & (pkt_next.op == OP_SBC)};
        case (pkt_next.op)
            OP_MOV: pkt_next.res = s;
            OP_ADD, OP_ADC: begin
                pkt_next.res = sum17[15:0];
                pkt_next.cy  = sum17[16];
            end
            OP_SUB, OP_SBC: begin
                pkt_next.res = dif17[15:0];
                pkt_next.cy  = dif17[16];
            end
            OP_UMUL, OP_SMUL, OP_MULC: pkt_next.res = d;
            OP_UDIV, OP_SDIV, OP_UMOD, OP_SMOD: begin
                pkt_next.dz = (s == '0);
                pkt_next.wr = (s != '0);
            end
            OP_AND: pkt_next.res = d & s;
            OP_OR:  pkt_next.res = d | s;
            OP_XOR: pkt_next.res = d ^ s;
            OP_NOT: pkt_next.res = ~d;
            OP_NEG: pkt_next.res = -d;
            OP_INC: begin
                pkt_next.res = d + 16'd1;
                pkt_next.cy  = (d == 16'hFFFF);
            end
            OP_DEC: begin
                pkt_next.res = d - 16'd1;
                pkt_next.cy  = (d == '0);
            end
            OP_SHL: begin
                pkt_next.res = big ? '0 : (d << rot);
                pkt_next.cy  = d[15];
            end
            OP_SHR: pkt_next.res = big ? '0 : (d >> rot);
            OP_SAR: pkt_next.res = big ? {DATA_W{d[15]}} : 16'($signed(d) >>> rot);
            OP_ROL: pkt_next.res = dd[(5'd16 - {1'b0, rot}) +: DATA_W];
            OP_ROR: pkt_next.res = dd[{1'b0, rot} +: DATA_W];
            OP_BTST: begin
                pkt_next.wr = 1'b0;
                pkt_next.zf = ~d[rot];
            end
            OP_UCMP: begin
                pkt_next.wr = 1'b0;
                pkt_next.cy = (d < s);
                pkt_next.zf = (d == s);
            end
            OP_SCMP: begin
                pkt_next.wr = 1'b0;
                pkt_next.cy = ($signed(d) < $signed(s));
                pkt_next.zf = (d == s);
            end
            default: begin
                pkt_next.ill = 1'b1;
                pkt_next.wr  = 1'b0;
            end
        endcase

        div_next.rem = '0;
        div_next.den = (pkt_next.op == OP_SDIV && s[15]) ? -s : s;
        div_next.n_q = ((pkt_next.op == OP_SDIV || pkt_next.op == OP_SMOD) && d[15]) ? -d : d;
    end

    assign s_tready = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            pkt_reg <= pkt_next;
            div_reg <= div_next;
        end
    end

    assign valid_o = valid_reg;
    assign pkt_o   = pkt_reg;
    assign div_o   = div_reg;

endmodule

FILE: rtl/cafl_div_stage.sv
// One stage of the pipelined restoring divider: one quotient bit per stage.
// The instruction packet rides along unchanged. Depends on cafl_pkg.
module cafl_div_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           valid_i,
    output logic           ready_o,
    input  cafl_pkg::pkt_t pkt_i,
    input  cafl_pkg::div_t div_i,
    output logic           valid_o,
    input  logic           ready_i,
    output cafl_pkg::pkt_t pkt_o,
    output cafl_pkg::div_t div_o
);
    import cafl_pkg::*;

    logic            valid_reg;
    pkt_t            pkt_reg;
    div_t            div_reg, div_next;
    logic [DATA_W:0] trial, diff;

    always_comb begin
        trial = {div_i.rem, div_i.n_q[DATA_W-1]};
        diff  = trial - {1'b0, div_i.den};
        div_next.den = div_i.den;
        if (!diff[DATA_W]) begin
            div_next.rem = diff[DATA_W-1:0];
            div_next.n_q = {div_i.n_q[DATA_W-2:0], 1'b1};
        end else begin
            div_next.rem = trial[DATA_W-1:0];
            div_next.n_q = {div_i.n_q[DATA_W-2:0], 1'b0};
        end
    end

    assign ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            pkt_reg <= pkt_i;
            div_reg <= div_next;
        end
    end

    assign valid_o = valid_reg;
    assign pkt_o   = pkt_reg;
    assign div_o   = div_reg;

endmodule

FILE: rtl/cafl_post.sv
// Last stage: finishes multiply and divide results, sets the zero flag and
// holds the output register of the result channel. Depends on cafl_pkg.
module cafl_post (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            valid_i,
    output logic                            ready_o,
    input  cafl_pkg::pkt_t                  pkt_i,
    input  cafl_pkg::div_t                  div_i,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cafl_pkg::M_TDATA_W-1:0]  m_tdata
);
    import cafl_pkg::*;

    logic              valid_reg;
    logic [RES_W-1:0]  out_reg, out_next;
    logic [DATA_W-1:0] res, lo, hi, hi_s;
    logic              cy;
    logic              zf;
    logic [DATA_W:0]   mc17;

    assign lo   = pkt_i.prod[DATA_W-1:0];
    assign hi   = pkt_i.prod[2*DATA_W-1:DATA_W];
    // Signed high half from the unsigned product.
    assign hi_s = hi - (pkt_i.dval[15] ? pkt_i.sval : '0)
                     - (pkt_i.sval[15] ? pkt_i.dval : '0);
    assign mc17 = {1'b0, lo} + {16'h0, pkt_i.ci};

    always_comb begin
        res = pkt_i.res;
        cy  = pkt_i.cy;
        case (pkt_i.op)
            OP_UMUL: begin
                res = lo;
                cy  = (hi != '0);
            end
            OP_SMUL: begin
                res = lo;
                cy  = !hi_s[15] && ((hi_s != '0) || lo[15]);
            end
            OP_MULC: begin
                res = mc17[DATA_W-1:0];
                cy  = (hi != '0) || mc17[DATA_W];
            end
            OP_UDIV: if (!pkt_i.dz) res = div_i.n_q;
            OP_SDIV: if (!pkt_i.dz) res = pkt_i.neg_q ? -div_i.n_q : div_i.n_q;
            OP_UMOD: if (!pkt_i.dz) res = div_i.rem;
            OP_SMOD: begin
                if (!pkt_i.dz) begin
                    res = (pkt_i.neg_r && div_i.rem != '0) ? div_i.den - div_i.rem
                                                           : div_i.rem;
                end
            end
            default: res = pkt_i.res;
        endcase
        zf = pkt_i.zf
             || (pkt_i.op != OP_UCMP && pkt_i.op != OP_SCMP && res == '0);
        out_next = {pkt_i.dz, pkt_i.ill, pkt_i.wr, zf, cy, res};
    end

    assign ready_o = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, out_reg};

endmodule

FILE: rtl/cpu_alu_with_flags.sv
// Top level of the 16-bit ALU with flags.
// Chains the prep stage, the divider stages and the post stage. Depends on
// cafl_pkg, cafl_prep, cafl_div_stage and cafl_post.
//
// Usage: one instruction enters per transfer on the s_ channel and one result
// leaves per transfer on the m_ channel, in the same order. Every opcode,
// including multiply, divide and modulo, goes down the same pipeline, so
// the block takes a new instruction each cycle unless every stage is full and the receiver stalls.
//
// An input transfer reaches m_tvalid through, in order, operand preparation and
// the simple operations (the multiplier is registered here), the restoring
// divider, which produces one quotient bit per stage, and the result fix-up,
// which is also the output register.
//
// Each stage has its own valid bit and takes a new packet whenever it is empty
// or its successor takes the packet it holds. When the receiver stalls, the
// results pile up in the stages and s_tready falls only once every stage is
// full; nothing is dropped or repeated. A synchronous low on aresetn empties
// all stages; payload registers are not cleared.
module cpu_alu_with_flags (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd[4:0], dest_value[20:5], src_value[36:21], carry_in[37], zeros above
    input  logic [cafl_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result[15:0], carry_out[16], zero_out[17], writes_dest[18],
    // illegal_op[19], divide_by_zero[20], zeros above
    output logic [cafl_pkg::M_TDATA_W-1:0]  m_tdata
);
    import cafl_pkg::*;

    // Index 0 is the prep stage output; index i+1 is divider stage i output.
    logic vld [0:DIV_STEPS];
    logic rdy [0:DIV_STEPS];
    pkt_t pkt [0:DIV_STEPS];
    div_t dvs [0:DIV_STEPS];

    cafl_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .valid_o  (vld[0]),
        .ready_i  (rdy[0]),
        .pkt_o    (pkt[0]),
        .div_o    (dvs[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        cafl_div_stage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .valid_i (vld[i]),
            .ready_o (rdy[i]),
            .pkt_i   (pkt[i]),
            .div_i   (dvs[i]),
            .valid_o (vld[i+1]),
            .ready_i (rdy[i+1]),
            .pkt_o   (pkt[i+1]),
            .div_o   (dvs[i+1])
        );
    end

    cafl_post u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .valid_i  (vld[DIV_STEPS]),
        .ready_o  (rdy[DIV_STEPS]),
        .pkt_i    (pkt[DIV_STEPS]),
        .div_i    (dvs[DIV_STEPS]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/cafl_checker.sv
// Port-level checker for the ALU with flags, bound to the top level.
// Depends on cafl_pkg for the channel widths.
module cafl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cafl_pkg::M_TDATA_W-1:0]  m_tdata
);
    import cafl_pkg::*;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An unused opcode never writes back, never sets carry and never flags division by zero.
    a_illegal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> !m_tdata[18] && !m_tdata[16] && !m_tdata[20])
        else $error("illegal opcode result marked wrongly");

    // A division by zero writes nothing and clears carry.
    a_divzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] |-> !m_tdata[18] && !m_tdata[16])
        else $error("divide by zero result marked wrongly");

    // A written zero result always raises the zero flag.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] && m_tdata[15:0] == '0 |-> m_tdata[17])
        else $error("zero flag missing on zero result");

endmodule

bind cpu_alu_with_flags cafl_checker u_cafl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/cpu_alu_with_flags_tb.sv
// Testbench for the 16-bit ALU with flags: directed and random instructions,
// with every result checked against an in-bench prediction of the ALU.
// Depends on cafl_pkg and the cpu_alu_with_flags RTL.
`timescale 1ns / 100ps

module cpu_alu_with_flags_tb;
    import cafl_pkg::*;

    // One ALU answer, in the order of the m_tdata fields.
    typedef struct packed {
        logic        dz;
        logic        ill;
        logic        wr;
        logic        zf;
        logic        cy;
        logic [15:0] res;
    } alu_out_t;

    // Holds the predicted ALU answers in issue order and checks each result.
    class alu_scoreboard;
        alu_out_t pending[$];
        int       errors;
        int       checked;

        // Works out the ALU answer for one instruction.
        function alu_out_t predict_alu(logic [4:0] op, logic [15:0] d, logic [15:0] s,
                                       logic ci);
            alu_out_t o;
            logic [16:0] w17;
            logic [31:0] w32;
            int sd, ss, sp;
            int unsigned rot;
            o = '0;
            o.res = d;
            o.wr = 1'b1;
            sd = $signed(d);
            ss = $signed(s);
            rot = s[3:0];
            case (op)
                OP_MOV: o.res = s;
                OP_ADD: begin
                    w17 = {1'b0, d} + {1'b0, s};
                    o.res = w17[15:0]; o.cy = w17[16];
                end
                OP_SUB: begin
                    o.res = d - s; o.cy = d < s;
                end
                OP_UMUL: begin
                    w32 = {16'd0, d} * {16'd0, s};
                    o.res = w32[15:0]; o.cy = w32[31:16] != 0;
                end
                OP_SMUL: begin
                    sp = sd * ss;
                    o.res = sp[15:0]; o.cy = sp >= 32'sh8000;
                end
                OP_UDIV, OP_SDIV, OP_UMOD, OP_SMOD: begin
                    if (s == 0) begin
                        o.dz = 1'b1; o.wr = 1'b0;
                    end else if (op == OP_UDIV) begin
                        o.res = d / s;
                    end else if (op == OP_SDIV) begin
                        if (sd == -32768 && ss == -1) o.res = 16'h8000;
                        else begin
                            sp = sd / ss; o.res = sp[15:0];
                        end
                    end else if (op == OP_UMOD) begin
                        o.res = d % s;
                    end else begin
                        // Euclidean remainder against an unsigned divisor.
                        sp = sd % int'(s);
                        if (sp < 0) sp += int'(s);
                        o.res = sp[15:0];
                    end
                end
                OP_AND: o.res = d & s;
                OP_OR:  o.res = d | s;
                OP_XOR: o.res = d ^ s;
                OP_NOT: o.res = ~d;
                OP_NEG: o.res = -d;
                OP_INC: begin
                    o.res = d + 16'd1; o.cy = d == 16'hFFFF;
                end
                OP_DEC: begin
                    o.res = d - 16'd1; o.cy = d == 16'd0;
                end
                OP_SHL: begin
                    o.cy = d[15];
                    o.res = (s >= 16) ? 16'd0 : d << s;
                end
                OP_SHR: o.res = (s >= 16) ? 16'd0 : d >> s;
                OP_SAR: o.res = (s >= 16) ? {16{d[15]}} : 16'($signed(d) >>> s);
                OP_ROL: o.res = (rot == 0) ? d : 16'((d << rot) | (d >> (16 - rot)));
                OP_ROR: o.res = (rot == 0) ? d : 16'((d >> rot) | (d << (16 - rot)));
                OP_BTST: begin
                    o.wr = 1'b0; o.zf = ~d[rot];
                end
                OP_ADC: begin
                    w17 = {1'b0, d} + {1'b0, s} + ci;
                    o.res = w17[15:0]; o.cy = w17[16];
                end
                OP_SBC: begin
                    o.cy = {1'b0, d} < ({1'b0, s} + ci);
                    o.res = d - s - ci;
                end
                OP_MULC: begin
                    w32 = {16'd0, d} * {16'd0, s} + ci;
                    o.res = w32[15:0]; o.cy = w32[31:16] != 0;
                end
                OP_UCMP: begin
                    o.wr = 1'b0; o.cy = d < s; o.zf = d == s;
                end
                OP_SCMP: begin
                    o.wr = 1'b0; o.cy = sd < ss; o.zf = d == s;
                end
                default: begin
                    o.ill = 1'b1; o.wr = 1'b0;
                end
            endcase
            if (op < OP_UCMP && o.res == 0) o.zf = 1'b1;
            return o;
        endfunction

        function void note_instr(logic [4:0] op, logic [15:0] d, logic [15:0] s, logic ci);
            pending.push_back(predict_alu(op, d, s, ci));
        endfunction

        function void check_result(alu_out_t got);
            alu_out_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.res != want.res) begin
                $display("%0t: result expected %h actual %h", $time, want.res, got.res);
                errors++;
            end
            if (got.cy != want.cy) begin
                $display("%0t: carry_out expected %b actual %b", $time, want.cy, got.cy);
                errors++;
            end
            if (got.zf != want.zf) begin
                $display("%0t: zero_out expected %b actual %b", $time, want.zf, got.zf);
                errors++;
            end
            if (got.wr != want.wr) begin
                $display("%0t: writes_dest expected %b actual %b", $time, want.wr, got.wr);
                errors++;
            end
            if (got.ill != want.ill) begin
                $display("%0t: illegal_op expected %b actual %b", $time, want.ill, got.ill);
                errors++;
            end
            if (got.dz != want.dz) begin
                $display("%0t: divide_by_zero expected %b actual %b", $time, want.dz,
                         got.dz);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_INSTRS = 1680;
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 120;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // cmd[4:0], dest_value[20:5], src_value[36:21], carry_in[37], zeros above
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // result[15:0], carry_out[16], zero_out[17], writes_dest[18],
    // illegal_op[19], divide_by_zero[20], zeros above
    logic [M_TDATA_W-1:0] m_tdata;

    alu_scoreboard alu_sb;

    // Idle percentages for the sender and the receiver, changed per phase.
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_recv;
    int  idle_cycles;
    int  sent_count;

    cpu_alu_with_flags dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offers one instruction, with a random idle gap ahead of it, and holds it until
    // the transfer happens. The prediction is noted at the accepting edge.
    task automatic send_instr(logic [4:0] op, logic [15:0] d, logic [15:0] s, logic ci);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ci, s, d, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        alu_sb.note_instr(op, d, s, ci);
        sent_count++;
    endtask

    // Operand picker that favors the edges of the 16-bit range.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(7, 0))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'($urandom_range(31, 0));
            5: return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_instr();
        logic [4:0] op;
        logic [15:0] d, s;
        op = 5'($urandom_range(31, 0));
        d  = pick_operand();
        s  = pick_operand();
        // Shift and rotate amounts are mostly kept in the interesting range.
        if ((op >= OP_SHL && op <= OP_BTST) && $urandom_range(3, 0) != 0)
            s = 16'($urandom_range(17, 0));
        send_instr(op, d, s, 1'($urandom));
    endtask

    // Receiver: random back-pressure, plus the long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_recv) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Results are checked at the edge that completes the transfer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            alu_sb.check_result(m_tdata[20:0]);
    end

    // Watchdog: counts cycles with no transfer on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Long receiver hold-off, counted in its own process, while the sender keeps
    // offering instructions so that the pipeline fills and s_tready falls.
    initial begin
        hold_recv = 1'b0;
        wait (sent_count >= 40);
        @(posedge aclk);
        hold_recv = 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        hold_recv = 1'b0;
    end

    initial begin
        int directed;
        alu_sb = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        sent_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: operand extremes, every opcode, and the special cases such as
        // signed division overflow, division by zero, large shifts and bit test.
        send_instr(OP_ADD,  16'hFFFF, 16'hFFFF, 1'b1);
        send_instr(OP_SDIV, 16'h8000, 16'hFFFF, 1'b0);
        send_instr(OP_UDIV, 16'h1234, 16'h0000, 1'b1);
        send_instr(OP_SMOD, 16'h8000, 16'h0000, 1'b0);
        send_instr(OP_SMOD, 16'hFFF9, 16'h0005, 1'b0);
        send_instr(OP_SMOD, 16'h8001, 16'hFFFF, 1'b0);
        send_instr(OP_SDIV, 16'hFFF9, 16'h0002, 1'b0);
        send_instr(OP_SAR,  16'h8000, 16'h0010, 1'b0);
        send_instr(OP_SAR,  16'h8421, 16'h0000, 1'b0);
        send_instr(OP_SHL,  16'h8001, 16'hFFFF, 1'b0);
        send_instr(OP_SHR,  16'hFFFF, 16'h000F, 1'b0);
        send_instr(OP_ROL,  16'h8001, 16'h0011, 1'b0);
        send_instr(OP_ROR,  16'h8001, 16'h0010, 1'b0);
        send_instr(OP_BTST, 16'h8000, 16'h001F, 1'b0);
        send_instr(OP_SMUL, 16'h8000, 16'h8000, 1'b0);
        send_instr(OP_MULC, 16'hFFFF, 16'hFFFF, 1'b1);
        send_instr(OP_SBC,  16'h0000, 16'hFFFF, 1'b1);
        send_instr(OP_INC,  16'hFFFF, 16'h0000, 1'b0);
        send_instr(OP_DEC,  16'h0000, 16'h0000, 1'b0);
        send_instr(5'd27,   16'h0000, 16'hFFFF, 1'b1);
        send_instr(OP_SCMP, 16'h8000, 16'h7FFF, 1'b0);
        send_instr(OP_UCMP, 16'h8000, 16'h8000, 1'b0);
        // Then one of each opcode on random operands.
        for (int op = 0; op < 32; op++)
            send_instr(5'(op), 16'($urandom), 16'($urandom), 1'($urandom));
        directed = sent_count;

        // Random part in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 35 : 0;
            for (int i = 0; i < RANDOM_INSTRS / 3; i++) begin
                random_instr();
            end
        end
        s_tvalid <= 1'b0;

        while (alu_sb.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        $display("Ran %0d instructions (%0d directed), %0d results checked, %0d errors.",
                 sent_count, directed, alu_sb.checked, alu_sb.errors);
        $display("Covered all opcodes, operand extremes, stalls on both sides.");
        if (alu_sb.errors == 0 && alu_sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
